// File: src/bis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear image scaler package
// Shared item types, operation codes and register indexes.
// ----------------------------------------------------------------------------
package bis_pkg;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_INV_SCALE  = 2'd2;
    localparam logic [1:0] REG_INTERP     = 2'd3;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    typedef struct packed {
        logic        op;
        logic [12:0] coord_x;
        logic [12:0] coord_y;
        logic [7:0]  in_red;
        logic [7:0]  in_green;
        logic [7:0]  in_blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_out_item;

endpackage

// File: src/bilinear_image_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear image scaler
// Frame store with nearest-neighbour or bilinear sampling of RGB pixels.
// ----------------------------------------------------------------------------
// One item is accepted in every cycle; busy stays low. A sample item passes
// through the coordinate multiply, the index clamp, the four-bank store read,
// two weight stages and the weighted sum, and gives its result on o_result
// with o_strobe; the receiver cannot hold it off. A load item gives no result
// and, if its coordinates lie below MAX_WIDTH and MAX_HEIGHT, writes the
// frame store in the cycle after it is accepted. The store is four banks
// split by column and row parity, so the four neighbours of a bilinear
// sample are read together in the same cycle. Entries are undefined until loaded.
module bilinear_image_scaler
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  t_in_item               i_item,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_strobe,
    output t_out_item              o_result
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int BXW = (XW > 1) ? XW - 1 : 1;
    localparam int BYW = (YW > 1) ? YW - 1 : 1;
    localparam int BAW = BXW + BYW;
    localparam int BANK_DEPTH = 1 << BAW;
    localparam logic [13:0] MAXW_C = 14'(MAX_WIDTH);
    localparam logic [13:0] MAXH_C = 14'(MAX_HEIGHT);

    // configuration
    logic [9:0]  r_src_width, r_src_height;
    logic [15:0] r_inv_scale;
    logic        r_interp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= 10'd512;
            r_src_height <= 10'd512;
            r_inv_scale  <= 16'd4096;
            r_interp     <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SRC_WIDTH:  r_src_width  <= i_cfg_data[9:0];
                REG_SRC_HEIGHT: r_src_height <= i_cfg_data[9:0];
                REG_INV_SCALE:  r_inv_scale  <= i_cfg_data;
                REG_INTERP:     r_interp     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective size minus one, at 14 bits so it compares with indices.
    logic [13:0] w_last, h_last;
    always_comb begin
        if (r_src_width == 10'd0)               w_last = 14'd0;
        else if ({4'd0, r_src_width} > MAXW_C)  w_last = MAXW_C - 14'd1;
        else                                    w_last = {4'd0, r_src_width} - 14'd1;
        if (r_src_height == 10'd0)              h_last = 14'd0;
        else if ({4'd0, r_src_height} > MAXH_C) h_last = MAXH_C - 14'd1;
        else                                    h_last = {4'd0, r_src_height} - 14'd1;
    end

    assign busy = 1'b0;
    logic acc;
    assign acc = start && !busy;

    // Stage 1: multiply, and register the load.
    logic        r1_v, r1_ld;
    logic [24:0] r1_px, r1_py;
    logic [12:0] r1_lx, r1_ly;
    logic [23:0] r1_rgb;
    logic [28:0] prod_x, prod_y;
    assign prod_x = {16'd0, i_item.coord_x} * {13'd0, r_inv_scale};
    assign prod_y = {16'd0, i_item.coord_y} * {13'd0, r_inv_scale};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r1_ld <= 1'b0;
        end else begin
            r1_v  <= acc && (i_item.op == OP_SAMPLE);
            r1_ld <= acc && (i_item.op == OP_LOAD)
                     && ({1'b0, i_item.coord_x} < MAXW_C)
                     && ({1'b0, i_item.coord_y} < MAXH_C);
        end
        r1_px  <= prod_x[28:4];
        r1_py  <= prod_y[28:4];
        r1_lx  <= i_item.coord_x;
        r1_ly  <= i_item.coord_y;
        r1_rgb <= {i_item.in_red, i_item.in_green, i_item.in_blue};
    end

    // Stage 2: indices and clamping.
    logic [17:0] ix0, iy0, ix1, iy1;
    logic [7:0]  fa, fb;
    always_comb begin
        if (r_interp) begin
            ix0 = {1'b0, r1_px[24:8]};
            iy0 = {1'b0, r1_py[24:8]};
            fa  = r1_px[7:0];
            fb  = r1_py[7:0];
            ix1 = ix0 + 18'd1;
            iy1 = iy0 + 18'd1;
        end else begin
            // Nearest mode uses only the rounded entry, never its neighbours.
            ix0 = 18'(({1'b0, r1_px} + 26'd128) >> 8);
            iy0 = 18'(({1'b0, r1_py} + 26'd128) >> 8);
            fa  = 8'd0;
            fb  = 8'd0;
            ix1 = ix0;
            iy1 = iy0;
        end
    end

    logic        r2_v;
    logic [13:0] r2_x0, r2_x1, r2_y0, r2_y1;
    logic [7:0]  r2_a, r2_b;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        r2_x0 <= (ix0 > {4'd0, w_last}) ? w_last : ix0[13:0];
        r2_x1 <= (ix1 > {4'd0, w_last}) ? w_last : ix1[13:0];
        r2_y0 <= (iy0 > {4'd0, h_last}) ? h_last : iy0[13:0];
        r2_y1 <= (iy1 > {4'd0, h_last}) ? h_last : iy1[13:0];
        r2_a  <= fa;
        r2_b  <= fb;
    end

    // Four banks by (row parity, column parity). x0 and x1 differ by at most
    // one, so the even and odd column come from distinct banks unless equal.
    logic [23:0] bank0 [BANK_DEPTH];
    logic [23:0] bank1 [BANK_DEPTH];
    logic [23:0] bank2 [BANK_DEPTH];
    logic [23:0] bank3 [BANK_DEPTH];

    logic [1:0]     wsel;
    logic [BAW-1:0] waddr;
    assign wsel  = {r1_ly[0], r1_lx[0]};
    assign waddr = {r1_ly[BYW:1], r1_lx[BXW:1]};

    logic [13:0]    xe, xo, ye, yo;
    logic [BAW-1:0] a00, a01, a10, a11;
    assign xe  = r2_x0[0] ? r2_x1 : r2_x0;
    assign xo  = r2_x0[0] ? r2_x0 : r2_x1;
    assign ye  = r2_y0[0] ? r2_y1 : r2_y0;
    assign yo  = r2_y0[0] ? r2_y0 : r2_y1;
    assign a00 = {ye[BYW:1], xe[BXW:1]};
    assign a01 = {ye[BYW:1], xo[BXW:1]};
    assign a10 = {yo[BYW:1], xe[BXW:1]};
    assign a11 = {yo[BYW:1], xo[BXW:1]};

    logic [23:0] r3_d0, r3_d1, r3_d2, r3_d3;
    always_ff @(posedge i_clk) begin
        if (r1_ld && wsel == 2'd0) bank0[waddr] <= r1_rgb;
        if (r1_ld && wsel == 2'd1) bank1[waddr] <= r1_rgb;
        if (r1_ld && wsel == 2'd2) bank2[waddr] <= r1_rgb;
        if (r1_ld && wsel == 2'd3) bank3[waddr] <= r1_rgb;
        r3_d0 <= bank0[a00];
        r3_d1 <= bank1[a01];
        r3_d2 <= bank2[a10];
        r3_d3 <= bank3[a11];
    end

    logic       r3_v;
    logic [1:0] r3_xs0, r3_xs1, r3_ys0, r3_ys1;
    logic [7:0] r3_a, r3_b;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
        r3_xs0 <= {1'b0, r2_x0[0]};
        r3_xs1 <= {1'b0, r2_x1[0]};
        r3_ys0 <= {1'b0, r2_y0[0]};
        r3_ys1 <= {1'b0, r2_y1[0]};
        r3_a   <= r2_a;
        r3_b   <= r2_b;
    end

    function automatic logic [23:0] pick(input logic ys, input logic xs,
                                         input logic [23:0] d0, input logic [23:0] d1,
                                         input logic [23:0] d2, input logic [23:0] d3);
        logic [1:0] s;
        s = {ys, xs};
        case (s)
            2'd0:    pick = d0;
            2'd1:    pick = d1;
            2'd2:    pick = d2;
            default: pick = d3;
        endcase
    endfunction

    // Stage 4: route bank data to neighbours, form the weights.
    logic        r4_v;
    logic [23:0] r4_p00, r4_p01, r4_p10, r4_p11;
    logic [16:0] r4_w00, r4_w01, r4_w10, r4_w11;
    logic [8:0]  na, nb;
    assign na = 9'd256 - {1'b0, r3_a};
    assign nb = 9'd256 - {1'b0, r3_b};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= r3_v;
        r4_p00 <= pick(r3_ys0[0], r3_xs0[0], r3_d0, r3_d1, r3_d2, r3_d3);
        r4_p01 <= pick(r3_ys0[0], r3_xs1[0], r3_d0, r3_d1, r3_d2, r3_d3);
        r4_p10 <= pick(r3_ys1[0], r3_xs0[0], r3_d0, r3_d1, r3_d2, r3_d3);
        r4_p11 <= pick(r3_ys1[0], r3_xs1[0], r3_d0, r3_d1, r3_d2, r3_d3);
        r4_w00 <= 17'(na * nb);
        r4_w01 <= 17'({1'b0, r3_a} * nb);
        r4_w10 <= 17'(na * {1'b0, r3_b});
        r4_w11 <= 17'({1'b0, r3_a} * {1'b0, r3_b});
    end

    // Stage 5: twelve channel products.
    logic        r5_v;
    logic [24:0] r5_m [12];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else          r5_v <= r4_v;
        for (int c = 0; c < 3; c++) begin
            r5_m[4*c+0] <= 25'(r4_p00[16-8*c +: 8] * r4_w00);
            r5_m[4*c+1] <= 25'(r4_p01[16-8*c +: 8] * r4_w01);
            r5_m[4*c+2] <= 25'(r4_p10[16-8*c +: 8] * r4_w10);
            r5_m[4*c+3] <= 25'(r4_p11[16-8*c +: 8] * r4_w11);
        end
    end

    // Stage 6: pair sums; stage 7: final sum and truncation.
    logic        r6_v;
    logic [25:0] r6_s [6];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else          r6_v <= r5_v;
        for (int k = 0; k < 6; k++) begin
            r6_s[k] <= {1'b0, r5_m[2*k]} + {1'b0, r5_m[2*k+1]};
        end
    end

    logic [26:0] sr, sg, sb;
    assign sr = {1'b0, r6_s[0]} + {1'b0, r6_s[1]};
    assign sg = {1'b0, r6_s[2]} + {1'b0, r6_s[3]};
    assign sb = {1'b0, r6_s[4]} + {1'b0, r6_s[5]};

    logic r7_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else          r7_v <= r6_v;
        o_result.out_red   <= sr[23:16];
        o_result.out_green <= sg[23:16];
        o_result.out_blue  <= sb[23:16];
    end
    assign o_strobe = r7_v;

endmodule
